>>> sv/cop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Center of pressure package
// Shared widths, constants and the beat types passed between the front end,
// the queue and the arithmetic back end.
// ----------------------------------------------------------------------------
package cop_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int DATA_W        = 32;
    localparam int THR_W         = 31;
    // Dividend magnitude: a 32-bit magnitude shifted left by the fraction bits.
    localparam int NUM_W         = DATA_W + FRACTION_BITS;
    // Quotient bits kept; anything above 2^31 saturates anyway.
    localparam int QUO_W         = DATA_W + 1;
    localparam int SQ_W          = 2 * DATA_W + 1;
    localparam int ROOT_W        = DATA_W + 1;
    localparam int THR_RESET     = 16384;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;

    // Beat that the front end classifies and hands to the back end.
    typedef struct packed {
        logic              valid_force;
        logic [DATA_W-1:0] den_mag;
        logic [DATA_W-1:0] numx_mag;
        logic [DATA_W-1:0] numy_mag;
        logic              negx;
        logic              negy;
    } cop_job_t;

    // Beat that leaves the block.
    typedef struct packed {
        logic              pvalid;
        logic [DATA_W-1:0] px;
        logic [DATA_W-1:0] py;
        logic [THR_W-1:0]  distance;
    } cop_res_t;

endpackage

>>> sv/center_of_pressure.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Center of pressure
// Computes the center of pressure and its distance from center from a
// normal force and two torques.
// ----------------------------------------------------------------------------
// The block accepts one beat per cycle while no stall holds it and returns
// one result beat per input beat, in order. A result beat passes through
// a front register, a four-entry queue, a divider input register and
// 48 bit-per-stage divider stages, saturation and squaring stages, a root
// input register and 33 bit-per-stage root stages, and an output register.
// A stalled result holds the whole back end. The threshold
// register may be written only while the block is idle.
module center_of_pressure (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [cop_pkg::DATA_W-1:0]  normal_force,
    input  logic signed [cop_pkg::DATA_W-1:0]  torque_about_x,
    input  logic signed [cop_pkg::DATA_W-1:0]  torque_about_y,
    input  logic                               cfg_we,
    input  logic [cop_pkg::THR_W-1:0]          cfg_wdata,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               pressure_valid,
    output logic signed [cop_pkg::DATA_W-1:0]  pressure_x,
    output logic signed [cop_pkg::DATA_W-1:0]  pressure_y,
    output logic [cop_pkg::THR_W-1:0]          center_distance
);

    logic [cop_pkg::THR_W-1:0] threshold_reg;
    logic                      fj_valid;
    logic                      fj_ready;
    cop_pkg::cop_job_t         fj;
    logic                      qj_valid;
    logic                      qj_ready;
    cop_pkg::cop_job_t         qj;
    cop_pkg::cop_res_t         res;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= cop_pkg::THR_W'(cop_pkg::THR_RESET);
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    cop_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .normal_force   (normal_force),
        .torque_about_x (torque_about_x),
        .torque_about_y (torque_about_y),
        .threshold      (threshold_reg),
        .job_valid      (fj_valid),
        .job_ready      (fj_ready),
        .job            (fj)
    );

    cop_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fj_valid),
        .wr_ready (fj_ready),
        .wr_data  (fj),
        .rd_valid (qj_valid),
        .rd_ready (qj_ready),
        .rd_data  (qj)
    );

    cop_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qj_valid),
        .job_ready (qj_ready),
        .job       (qj),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign pressure_valid  = res.pvalid;
    assign pressure_x      = res.px;
    assign pressure_y      = res.py;
    assign center_distance = res.distance;

endmodule

>>> sv/cop_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Center of pressure front end
// Accepts sensor beats, compares the force magnitude with the threshold and
// splits operands into magnitudes and quotient signs.
// ----------------------------------------------------------------------------
module cop_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [cop_pkg::DATA_W-1:0]      normal_force,
    input  logic signed [cop_pkg::DATA_W-1:0]      torque_about_x,
    input  logic signed [cop_pkg::DATA_W-1:0]      torque_about_y,
    input  logic [cop_pkg::THR_W-1:0]              threshold,
    output logic                                   job_valid,
    input  logic                                   job_ready,
    output cop_pkg::cop_job_t                      job
);

    logic              valid_reg;
    cop_pkg::cop_job_t job_reg;
    cop_pkg::cop_job_t job_next;

    assign in_ready  = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    // Magnitudes and signs; the quotient is negated when signs agree.
    always_comb
    begin
        job_next.den_mag  = normal_force[cop_pkg::DATA_W-1] ?
                            (~normal_force + 1'b1) : normal_force;
        job_next.numx_mag = torque_about_y[cop_pkg::DATA_W-1] ?
                            (~torque_about_y + 1'b1) : torque_about_y;
        job_next.numy_mag = torque_about_x[cop_pkg::DATA_W-1] ?
                            (~torque_about_x + 1'b1) : torque_about_x;
        job_next.negx = torque_about_y[cop_pkg::DATA_W-1] ==
                        normal_force[cop_pkg::DATA_W-1];
        job_next.negy = torque_about_x[cop_pkg::DATA_W-1] ==
                        normal_force[cop_pkg::DATA_W-1];
        job_next.valid_force = job_next.den_mag > {1'b0, threshold};
    end

    // Output stage toward the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            job_reg <= job_next;
        end
    end

endmodule

>>> sv/cop_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Center of pressure job queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module cop_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  cop_pkg::cop_job_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output cop_pkg::cop_job_t rd_data
);

    cop_pkg::cop_job_t                mem [cop_pkg::QUEUE_DEPTH];
    logic [cop_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [cop_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [cop_pkg::QUEUE_AW:0]       count_reg;
    logic                             push;
    logic                             pop;

    assign wr_ready = count_reg != (cop_pkg::QUEUE_AW+1)'(cop_pkg::QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/cop_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Center of pressure back end
// Pipelined restoring dividers (one quotient bit per stage), saturation,
// squaring and a pipelined square root (one root bit per stage). The whole
// pipeline advances only when its last stage can move, so a stall holds it.
// ----------------------------------------------------------------------------
module cop_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  cop_pkg::cop_job_t job,
    output logic              res_valid,
    input  logic              res_ready,
    output cop_pkg::cop_res_t res
);

    localparam int NW  = cop_pkg::NUM_W;
    localparam int DW  = cop_pkg::DATA_W;
    localparam int QW  = cop_pkg::QUO_W;
    localparam int SW  = cop_pkg::SQ_W;
    localparam int RW  = cop_pkg::ROOT_W;
    localparam int DIV_ST = NW;
    localparam int SQ_ST  = RW;

    // Divider stage state.
    typedef struct packed {
        logic          v;
        logic          vf;
        logic [DW-1:0] den;
        logic [DW:0]   remx;
        logic [DW:0]   remy;
        logic [NW-1:0] numx;
        logic [NW-1:0] numy;
        logic [QW-1:0] qx;
        logic [QW-1:0] qy;
        logic          negx;
        logic          negy;
    } div_st_t;

    // Root stage state.
    typedef struct packed {
        logic          v;
        logic          vf;
        logic [DW-1:0] px;
        logic [DW-1:0] py;
        logic [SW-1:0] rem;
        logic [RW-1:0] root;
    } sq_st_t;

    typedef struct packed {
        logic          v;
        logic          vf;
        logic [DW-1:0] px;
        logic [DW-1:0] py;
        logic [DW-1:0] mx;
        logic [DW-1:0] my;
    } sat_st_t;

    typedef struct packed {
        logic          v;
        logic          vf;
        logic [DW-1:0] px;
        logic [DW-1:0] py;
        logic [2*DW-1:0] sx;
        logic [2*DW-1:0] sy;
    } mul_st_t;

    div_st_t div_reg [DIV_ST+1];
    div_st_t div_next[DIV_ST+1];
    sat_st_t sat_reg;
    sat_st_t sat_next;
    mul_st_t mul_reg;
    mul_st_t mul_next;
    sq_st_t  sq_reg [SQ_ST+1];
    sq_st_t  sq_next[SQ_ST+1];
    logic    adv;
    cop_pkg::cop_res_t res_reg;
    cop_pkg::cop_res_t res_next;
    logic    out_valid_reg;

    assign adv       = !out_valid_reg || res_ready;
    assign job_ready = adv;
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    // Divider entry and one quotient bit per stage for both coordinates.
    always_comb
    begin
        logic [DW:0] tx;
        logic [DW:0] ty;
        div_next[0].v    = job_valid;
        div_next[0].vf   = job.valid_force;
        div_next[0].den  = job.den_mag;
        div_next[0].remx = '0;
        div_next[0].remy = '0;
        div_next[0].numx = {job.numx_mag, {cop_pkg::FRACTION_BITS{1'b0}}};
        div_next[0].numy = {job.numy_mag, {cop_pkg::FRACTION_BITS{1'b0}}};
        div_next[0].qx   = '0;
        div_next[0].qy   = '0;
        div_next[0].negx = job.negx;
        div_next[0].negy = job.negy;
        for (int i = 1; i <= DIV_ST; i++)
        begin
            div_next[i] = div_reg[i-1];
            tx = {div_reg[i-1].remx[DW-1:0], div_reg[i-1].numx[NW-1]};
            ty = {div_reg[i-1].remy[DW-1:0], div_reg[i-1].numy[NW-1]};
            div_next[i].numx = {div_reg[i-1].numx[NW-2:0], 1'b0};
            div_next[i].numy = {div_reg[i-1].numy[NW-2:0], 1'b0};
            // Sticky top bit of the quotient marks overflow past QW-1 bits.
            if (tx >= {1'b0, div_reg[i-1].den} && div_reg[i-1].den != '0)
            begin
                div_next[i].remx = tx - {1'b0, div_reg[i-1].den};
                div_next[i].qx   = {div_reg[i-1].qx[QW-1] | div_reg[i-1].qx[QW-2],
                                    div_reg[i-1].qx[QW-3:0], 1'b1};
            end
            else
            begin
                div_next[i].remx = tx;
                div_next[i].qx   = {div_reg[i-1].qx[QW-1] | div_reg[i-1].qx[QW-2],
                                    div_reg[i-1].qx[QW-3:0], 1'b0};
            end
            if (ty >= {1'b0, div_reg[i-1].den} && div_reg[i-1].den != '0)
            begin
                div_next[i].remy = ty - {1'b0, div_reg[i-1].den};
                div_next[i].qy   = {div_reg[i-1].qy[QW-1] | div_reg[i-1].qy[QW-2],
                                    div_reg[i-1].qy[QW-3:0], 1'b1};
            end
            else
            begin
                div_next[i].remy = ty;
                div_next[i].qy   = {div_reg[i-1].qy[QW-1] | div_reg[i-1].qy[QW-2],
                                    div_reg[i-1].qy[QW-3:0], 1'b0};
            end
        end
    end

    // Saturate each quotient with its sign; keep magnitudes for squaring.
    always_comb
    begin
        logic [QW-1:0] q;
        sat_next.v  = div_reg[DIV_ST].v;
        sat_next.vf = div_reg[DIV_ST].vf;
        q = div_reg[DIV_ST].qx;
        if (div_reg[DIV_ST].negx)
        begin
            sat_next.mx = (q > QW'(33'h080000000)) ? 32'h80000000 : q[DW-1:0];
            sat_next.px = ~sat_next.mx + 1'b1;
        end
        else
        begin
            sat_next.mx = (q > QW'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : q[DW-1:0];
            sat_next.px = sat_next.mx;
        end
        q = div_reg[DIV_ST].qy;
        if (div_reg[DIV_ST].negy)
        begin
            sat_next.my = (q > QW'(33'h080000000)) ? 32'h80000000 : q[DW-1:0];
            sat_next.py = ~sat_next.my + 1'b1;
        end
        else
        begin
            sat_next.my = (q > QW'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : q[DW-1:0];
            sat_next.py = sat_next.my;
        end
    end

    // Two 32x32 squares, one each.
    always_comb
    begin
        mul_next.v  = sat_reg.v;
        mul_next.vf = sat_reg.vf;
        mul_next.px = sat_reg.px;
        mul_next.py = sat_reg.py;
        mul_next.sx = sat_reg.mx * sat_reg.mx;
        mul_next.sy = sat_reg.my * sat_reg.my;
    end

    // Sum of squares into the root pipeline, then one root bit per stage.
    always_comb
    begin
        logic [SW-1:0] trial;
        sq_next[0].v    = mul_reg.v;
        sq_next[0].vf   = mul_reg.vf;
        sq_next[0].px   = mul_reg.px;
        sq_next[0].py   = mul_reg.py;
        sq_next[0].rem  = {1'b0, mul_reg.sx} + {1'b0, mul_reg.sy};
        sq_next[0].root = '0;
        for (int i = 1; i <= SQ_ST; i++)
        begin
            sq_next[i] = sq_reg[i-1];
            // Trial: (root << 2 | 1) << 2*(bit position).
            trial = ({{(SW-RW){1'b0}}, sq_reg[i-1].root} << (2 * (SQ_ST - i + 1)))
                    | (SW'(1) << (2 * (SQ_ST - i)));
            if (sq_reg[i-1].rem >= trial)
            begin
                sq_next[i].rem  = sq_reg[i-1].rem - trial;
                sq_next[i].root = {sq_reg[i-1].root[RW-2:0], 1'b1};
            end
            else
            begin
                sq_next[i].root = {sq_reg[i-1].root[RW-2:0], 1'b0};
            end
        end
    end

    // Final saturation and weak-force zeroing.
    always_comb
    begin
        res_next.pvalid = sq_reg[SQ_ST].vf;
        res_next.px     = sq_reg[SQ_ST].vf ? sq_reg[SQ_ST].px : '0;
        res_next.py     = sq_reg[SQ_ST].vf ? sq_reg[SQ_ST].py : '0;
        if (!sq_reg[SQ_ST].vf)
        begin
            res_next.distance = '0;
        end
        else if (sq_reg[SQ_ST].root[RW-1:cop_pkg::THR_W] != '0)
        begin
            res_next.distance = '1;
        end
        else
        begin
            res_next.distance = sq_reg[SQ_ST].root[cop_pkg::THR_W-1:0];
        end
    end

    // Registers of every stage, all advancing together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_ST; i++)
            begin
                div_reg[i] <= '0;
            end
            for (int i = 0; i <= SQ_ST; i++)
            begin
                sq_reg[i] <= '0;
            end
            sat_reg       <= '0;
            mul_reg       <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            for (int i = 0; i <= DIV_ST; i++)
            begin
                div_reg[i] <= div_next[i];
            end
            for (int i = 0; i <= SQ_ST; i++)
            begin
                sq_reg[i] <= sq_next[i];
            end
            sat_reg       <= sat_next;
            mul_reg       <= mul_next;
            res_reg       <= res_next;
            out_valid_reg <= sq_reg[SQ_ST].v;
        end
    end

endmodule
